// ===== rtl/core/wmt_pkg.sv =====
// shared types and constants for the window mean threshold block
`default_nettype none

package wmt_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_WINDOW = 8;
   localparam int MAX_HEIGHT     = 4096;

   localparam int PIX_W    = 8;
   localparam int ROW_W    = 12;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int WSIZE_W  = 4;
   localparam int THR_W    = 8;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd3;

   localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd1024;
   localparam logic [WSIZE_W-1:0]  RST_WINDOW_SIZE  = 4'd3;
   localparam logic [THR_W-1:0]    RST_THRESHOLD    = 8'd128;

   localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

   typedef struct packed {
      logic emit;
      logic last;
      logic row_start;
   } wmt_tag_type;

endpackage

`default_nettype wire

// ===== rtl/core/wmt_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module wmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wmt_line_buf.sv =====
// line store banks, same-column bypass and column sum stage
`default_nettype none

module wmt_line_buf #(
   parameter int MAX_WIDTH  = wmt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = wmt_pkg::DEF_MAX_WINDOW
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              advance,
   input  wire logic                                              s0_valid,
   input  wire logic [wmt_pkg::PIX_W-1:0]                         s0_pixel,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]                      s0_col,
   input  wire logic [wmt_pkg::ROW_W-1:0]                         s0_row,
   input  wire logic [((MAX_WINDOW > 2) ? $clog2(MAX_WINDOW-1) : 1)-1:0] s0_slot,
   input  wire wmt_pkg::wmt_tag_type                              s0_tag,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]                   k_eff,
   output logic                                                   s2_valid,
   output logic [wmt_pkg::PIX_W+$clog2(MAX_WINDOW)-1:0]           s2_colsum,
   output wmt_pkg::wmt_tag_type                                   s2_tag
);

   import wmt_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int KW         = $clog2(MAX_WINDOW+1);
   localparam int STORE_ROWS = MAX_WINDOW - 1;
   localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
   localparam int CSUM_W     = PIX_W + $clog2(MAX_WINDOW);

   logic [STORE_ROWS-1:0][PIX_W-1:0] bank_rd;
   logic [STORE_ROWS-1:0]            bank_wr;

   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_pixel_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   wmt_tag_type       s1_tag_ff;
   logic              fwd_hit_ff;
   logic [SLOT_W-1:0] fwd_slot_ff;
   logic [PIX_W-1:0]  fwd_data_ff;

   logic [KW-1:0]     row_gap;
   logic [PIX_W-1:0]  row_pix;
   logic [CSUM_W-1:0] colsum;

   logic              s2_valid_ff;
   logic [CSUM_W-1:0] s2_colsum_ff;
   wmt_tag_type       s2_tag_ff;

   for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
      assign bank_wr[b] = advance & s1_valid_ff & (s1_slot_ff == SLOT_W'(b));

      wmt_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_wr[b]),
         .wr_addr (s1_col_ff),
         .wr_data (s1_pixel_ff),
         .rd_en   (advance),
         .rd_addr (s0_col),
         .rd_data (bank_rd[b])
      );
   end

   // pixel from the previous transaction is written in the same cycle it is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid;
         fwd_hit_ff  <= s1_valid_ff & (s1_col_ff == s0_col);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pixel_ff <= s0_pixel;
         s1_col_ff   <= s0_col;
         s1_row_ff   <= s0_row;
         s1_slot_ff  <= s0_slot;
         s1_tag_ff   <= s0_tag;
         fwd_slot_ff <= s1_slot_ff;
         fwd_data_ff <= s1_pixel_ff;
      end
   end

   // row distance of each bank from the current row, and the column sum over the rows inside the window
   always_comb begin
      colsum  = CSUM_W'(s1_pixel_ff);
      row_gap = '0;
      row_pix = '0;
      for (int b = 0; b < STORE_ROWS; b++) begin
         if (s1_slot_ff > SLOT_W'(b)) begin
            row_gap = KW'(s1_slot_ff) - KW'(b);
         end else begin
            row_gap = KW'(s1_slot_ff) + KW'(STORE_ROWS) - KW'(b);
         end
         if (fwd_hit_ff && (fwd_slot_ff == SLOT_W'(b))) begin
            row_pix = fwd_data_ff;
         end else begin
            row_pix = bank_rd[b];
         end
         if ((row_gap < k_eff) && (ROW_W'(row_gap) <= s1_row_ff)) begin
            colsum = colsum + CSUM_W'(row_pix);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_colsum_ff <= colsum;
         s2_tag_ff    <= s1_tag_ff;
      end
   end

   assign s2_valid  = s2_valid_ff;
   assign s2_colsum = s2_colsum_ff;
   assign s2_tag    = s2_tag_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wmt_window.sv =====
// column sum history, window sum, threshold compare and result register
`default_nettype none

module wmt_window #(
   parameter int MAX_WINDOW = wmt_pkg::DEF_MAX_WINDOW
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire logic                                               s2_valid,
   input  wire logic [wmt_pkg::PIX_W+$clog2(MAX_WINDOW)-1:0]       s2_colsum,
   input  wire wmt_pkg::wmt_tag_type                               s2_tag,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]                    k_eff,
   input  wire logic [wmt_pkg::PIX_W+2*$clog2(MAX_WINDOW+1)-1:0]   limit,
   output logic                                                    advance,
   output logic                                                    rsp_valid,
   input  wire logic                                               rsp_ready,
   output logic [wmt_pkg::PIX_W-1:0]                               rsp_out_value,
   output logic                                                    rsp_frame_last
);

   import wmt_pkg::*;

   localparam int KW     = $clog2(MAX_WINDOW+1);
   localparam int CSUM_W = PIX_W + $clog2(MAX_WINDOW);
   localparam int WSUM_W = PIX_W + 2*$clog2(MAX_WINDOW);
   localparam int LIM_W  = PIX_W + 2*KW;

   logic [MAX_WINDOW-1:0][CSUM_W-1:0] hist_ff;
   logic [MAX_WINDOW-1:0][CSUM_W-1:0] hist_in;
   logic [WSUM_W-1:0]                 wsum;
   logic                              hot;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_value_ff;
   logic             rsp_last_ff;

   assign advance = ~rsp_valid_ff | rsp_ready;

   // history restarts at the first column of each row; window sum and threshold compare
   always_comb begin
      hist_in[0] = s2_colsum;
      for (int j = 1; j < MAX_WINDOW; j++) begin
         hist_in[j] = s2_tag.row_start ? '0 : hist_ff[j-1];
      end
      wsum = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         if (KW'(j) < k_eff) begin
            wsum = wsum + WSUM_W'(hist_in[j]);
         end
      end
      hot = LIM_W'(wsum) > limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid & s2_tag.emit;
         if (s2_valid) begin
            hist_ff <= hist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= hot ? PIX_ON : PIX_OFF;
         rsp_last_ff  <= s2_tag.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_frame_last = rsp_last_ff;

   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(hist_ff))
      else $error("column history changed while stalled");

   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid && s2_tag.row_start) |=> (hist_ff[1] == '0))
      else $error("column history not cleared at row start");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid && s2_tag.emit) |=> rsp_valid_ff)
      else $error("window result lost");

endmodule

`default_nettype wire

// ===== rtl/core/window_mean_threshold.sv =====
// top level of the sliding window mean threshold block
`default_nettype none

// Takes one 8-bit pixel per clock in raster order and, for every pixel that
// completes a full square window of the configured side, returns 255 when the
// window sum exceeds threshold times the side squared and 0 otherwise, with
// frame_last on the final result of the frame. Sustained rate is one pixel
// per clock while the result channel is not stalled. A pixel passes the input
// register, the line store read stage, the column sum register and the result
// register; the line store banks (one per stored row, MAX_WINDOW-1 banks of
// MAX_WIDTH pixels) are read from the input register stage and written from
// the stage after it. Back pressure on the result channel stalls the whole
// pipeline. Any register write restarts the frame. The line store needs no
// clearing pass: rows are read only after being written in the same frame.
// Register writes are taken at any time but are meant for an idle block.
module window_mean_threshold #(
   parameter int MAX_WIDTH  = wmt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = wmt_pkg::DEF_MAX_WINDOW
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [wmt_pkg::PIX_W-1:0]          req_pixel,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [wmt_pkg::PIX_W-1:0]               rsp_out_value,
   output logic                                    rsp_frame_last,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [wmt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [wmt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wmt_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   import wmt_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int W_W        = $clog2(MAX_WIDTH+1);
   localparam int KW         = $clog2(MAX_WINDOW+1);
   localparam int STORE_ROWS = MAX_WINDOW - 1;
   localparam int SLOT_W     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
   localparam int CSUM_W     = PIX_W + $clog2(MAX_WINDOW);
   localparam int LIM_W      = PIX_W + 2*KW;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WSIZE_W-1:0]  wsize_ff;
   logic [THR_W-1:0]    thr_ff;

   logic                 cfg_wr;
   logic [REG_IDX_W-1:0] cfg_idx;

   logic [W_W-1:0]      w_eff;
   logic [COL_W-1:0]    w_last;
   logic [HEIGHT_W-1:0] h_eff;
   logic [ROW_W-1:0]    h_last;
   logic [KW-1:0]       k_eff;
   logic [KW-1:0]       k_last;

   logic [2*KW-1:0]  ksq_ff;
   logic [LIM_W-1:0] limit_ff;

   logic              advance;
   logic              accept;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   wmt_tag_type       tag;

   logic              s0_valid_ff;
   logic [PIX_W-1:0]  s0_pixel_ff;
   logic [COL_W-1:0]  s0_col_ff;
   logic [ROW_W-1:0]  s0_row_ff;
   logic [SLOT_W-1:0] s0_slot_ff;
   wmt_tag_type       s0_tag_ff;

   logic              s2_valid;
   logic [CSUM_W-1:0] s2_colsum;
   wmt_tag_type       s2_tag;

   // register port
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         wsize_ff  <= RST_WINDOW_SIZE;
         thr_ff    <= RST_THRESHOLD;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[HEIGHT_W-1:0];
            REG_WINDOW_SIZE:  wsize_ff  <= csr_pwdata[WSIZE_W-1:0];
            REG_THRESHOLD:    thr_ff    <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_WINDOW_SIZE:  csr_prdata = CSR_DATA_W'(wsize_ff);
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(thr_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamped frame and window sizes
   always_comb begin
      if (width_ff == '0) begin
         w_eff = W_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(width_ff);
      end
      w_last = COL_W'(w_eff - W_W'(1));

      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      h_last = ROW_W'(h_eff - HEIGHT_W'(1));

      if (wsize_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(wsize_ff) > MAX_WINDOW) begin
         k_eff = KW'(MAX_WINDOW);
      end else begin
         k_eff = KW'(wsize_ff);
      end
      k_last = k_eff - KW'(1);
   end

   always_ff @(posedge clock) begin
      ksq_ff   <= (2*KW)'(k_eff) * (2*KW)'(k_eff);
      limit_ff <= LIM_W'(thr_ff) * LIM_W'(ksq_ff);
   end

   // position counters
   assign accept    = req_valid & advance;
   assign req_ready = advance;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (cfg_wr) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end else if (accept) begin
         if (col_ff == w_last) begin
            col_in = '0;
            if (row_ff == h_last) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
               if (slot_ff == SLOT_W'(STORE_ROWS - 1)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   always_comb begin
      tag.emit      = (int'(row_ff) >= int'(k_last)) && (int'(col_ff) >= int'(k_last));
      tag.last      = (row_ff == h_last) && (col_ff == w_last);
      tag.row_start = (col_ff == '0);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_pixel_ff <= req_pixel;
         s0_col_ff   <= col_ff;
         s0_row_ff   <= row_ff;
         s0_slot_ff  <= slot_ff;
         s0_tag_ff   <= tag;
      end
   end

   wmt_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .s0_valid  (s0_valid_ff),
      .s0_pixel  (s0_pixel_ff),
      .s0_col    (s0_col_ff),
      .s0_row    (s0_row_ff),
      .s0_slot   (s0_slot_ff),
      .s0_tag    (s0_tag_ff),
      .k_eff     (k_eff),
      .s2_valid  (s2_valid),
      .s2_colsum (s2_colsum),
      .s2_tag    (s2_tag)
   );

   wmt_window #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .s2_valid       (s2_valid),
      .s2_colsum      (s2_colsum),
      .s2_tag         (s2_tag),
      .k_eff          (k_eff),
      .limit          (limit_ff),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_frame_last (rsp_frame_last)
   );

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last)
      else $error("column counter outside the row");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last)
      else $error("row counter outside the frame");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg_wr && (col_ff != w_last)) |=> (col_ff == $past(col_ff) + COL_W'(1)))
      else $error("column counter did not step on transaction");

endmodule

`default_nettype wire
